// File: design/osp_pkg.sv
// Package: shared constants, types and state codes of the open shop scheduler.
package osp_pkg;

	localparam int MAX_JOBS     = 16;
	localparam int MAX_MACHINES = 8;
	localparam int TIME_BITS    = 16;
	localparam int FRAC_BITS    = 24;

	localparam int JOB_W      = $clog2(MAX_JOBS);
	localparam int MACH_W     = $clog2(MAX_MACHINES);
	localparam int ADDR_W     = JOB_W + MACH_W;
	localparam int TIME_DEPTH = MAX_JOBS * MAX_MACHINES;
	localparam int WEIGHT_W   = 16;
	localparam int ADJ_W      = WEIGHT_W + FRAC_BITS;
	localparam int LOAD_W     = 20;
	localparam int PROD_W     = LOAD_W + WEIGHT_W;
	localparam int SUM_W      = 40;
	localparam int DIV_CNT_W  = $clog2(ADJ_W + 1);

	localparam int CFG_IDX_W    = 1;
	localparam int CFG_JOBS_W   = 5;
	localparam int CFG_MACH_W   = 4;
	localparam int CFG_DATA_W   = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_JOBS     = 1'b0,
		CFG_MACHINES = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_MAX,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SCAN_DIV,
		S_SCAN_END,
		S_UPD_RD,
		S_UPD_MUL,
		S_UPD_WR,
		S_PICK,
		S_SUB,
		S_EMIT
	} sched_state_t;

	typedef struct packed {
		logic [JOB_W-1:0]     job_index;
		logic [MACH_W-1:0]    machine_index;
		logic [TIME_BITS-1:0] processing_time;
		logic [WEIGHT_W-1:0]  job_weight;
		logic                 last_entry;
	} load_t;

	typedef struct packed {
		logic [JOB_W-1:0]  schedule_position;
		logic [JOB_W-1:0]  scheduled_job;
		logic [LOAD_W-1:0] completion_time;
		logic [SUM_W-1:0]  weighted_sum;
		logic              last_result;
	} result_t;

	typedef struct packed {
		logic                 start;
		logic [ADJ_W-1:0]     dividend;
		logic [TIME_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [ADJ_W-1:0] quotient;
	} div_rsp_t;

endpackage

// File: design/osp_load_if.sv
// Interface: load channel carrying one processing time entry per item.
interface osp_load_if;
	logic                            valid;
	logic                            ready;
	logic [osp_pkg::JOB_W-1:0]       job_index;
	logic [osp_pkg::MACH_W-1:0]      machine_index;
	logic [osp_pkg::TIME_BITS-1:0]   processing_time;
	logic [osp_pkg::WEIGHT_W-1:0]    job_weight;
	logic                            last_entry;

	modport source (
		output valid, job_index, machine_index, processing_time, job_weight, last_entry,
		input  ready
	);
	modport sink (
		input  valid, job_index, machine_index, processing_time, job_weight, last_entry,
		output ready
	);
endinterface

// File: design/osp_result_if.sv
// Interface: result channel carrying one schedule position per item.
interface osp_result_if;
	logic                          valid;
	logic                          ready;
	logic [osp_pkg::JOB_W-1:0]     schedule_position;
	logic [osp_pkg::JOB_W-1:0]     scheduled_job;
	logic [osp_pkg::LOAD_W-1:0]    completion_time;
	logic [osp_pkg::SUM_W-1:0]     weighted_sum;
	logic                          last_result;

	modport source (
		output valid, schedule_position, scheduled_job, completion_time, weighted_sum,
		output last_result,
		input  ready
	);
	modport sink (
		input  valid, schedule_position, scheduled_job, completion_time, weighted_sum,
		input  last_result,
		output ready
	);
endinterface

// File: design/osp_div.sv
// Restoring divider: adjusted weight over processing time, one quotient bit per cycle.
module osp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  osp_pkg::div_req_t req,
	output osp_pkg::div_rsp_t rsp
);

	logic                             busy_q;
	logic                             done_q;
	logic [osp_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [osp_pkg::TIME_BITS-1:0]    rem_q;
	logic [osp_pkg::TIME_BITS-1:0]    dvs_q;
	logic [osp_pkg::ADJ_W-1:0]        quot_q;
	logic [osp_pkg::TIME_BITS:0]      rem_sh;
	logic [osp_pkg::TIME_BITS:0]      diff;
	logic                             ge;
	logic                             cnt_last;

	assign rem_sh   = {rem_q, quot_q[osp_pkg::ADJ_W-1]};
	assign diff     = rem_sh - {1'b0, dvs_q};
	assign ge       = rem_sh >= {1'b0, dvs_q};
	assign cnt_last = cnt_q == osp_pkg::DIV_CNT_W'(osp_pkg::ADJ_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && cnt_last;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			quot_q <= req.dividend;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[osp_pkg::TIME_BITS-1:0] : rem_sh[osp_pkg::TIME_BITS-1:0];
			quot_q <= {quot_q[osp_pkg::ADJ_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q;

endmodule

// File: design/osp_sched.sv
// Scheduler core: time and adjusted weight memories with the read-modify-write sequencer.
module osp_sched (
	input  logic                         clk,
	input  logic                         arst_n,
	input  osp_pkg::load_t               ld,
	input  logic                         ld_fire,
	input  logic [osp_pkg::JOB_W-1:0]    nj_m1,
	input  logic [osp_pkg::MACH_W-1:0]   nm_m1,
	input  logic                         res_free,
	output logic                         idle,
	output logic                         res_push,
	output osp_pkg::result_t             res
);

	osp_pkg::sched_state_t state_q, state_d;

	logic [osp_pkg::TIME_BITS-1:0] time_mem [osp_pkg::TIME_DEPTH];
	logic [osp_pkg::ADJ_W-1:0]     adj_mem [osp_pkg::MAX_JOBS];
	logic [osp_pkg::WEIGHT_W-1:0]  w_q [osp_pkg::MAX_JOBS];
	logic [osp_pkg::LOAD_W-1:0]    loads_q [osp_pkg::MAX_MACHINES];

	logic [osp_pkg::TIME_BITS-1:0] t_rd;
	logic [osp_pkg::ADJ_W-1:0]     adj_rd;
	logic [osp_pkg::ADDR_W-1:0]    tm_raddr;
	logic                          adj_we;
	logic [osp_pkg::ADJ_W-1:0]     adj_wdata;

	logic [osp_pkg::JOB_W-1:0]     j_q;
	logic [osp_pkg::MACH_W-1:0]    i_q;
	logic [osp_pkg::JOB_W-1:0]     k_q;
	logic [osp_pkg::MAX_JOBS-1:0]  flag_q;
	logic                          found_q;
	logic                          first_v_q;
	logic [osp_pkg::JOB_W-1:0]     first_q;
	logic [osp_pkg::JOB_W-1:0]     pick_q;
	logic [osp_pkg::ADJ_W-1:0]     best_q;
	logic [osp_pkg::LOAD_W-1:0]    top_q;
	logic [osp_pkg::MACH_W-1:0]    mu_q;
	logic [osp_pkg::ADJ_W-1:0]     prod_s1;
	logic [osp_pkg::ADJ_W-1:0]     adj_s1;
	logic [osp_pkg::PROD_W-1:0]    wprod_q;
	logic [osp_pkg::SUM_W-1:0]     total_q;

	logic                          sw_v_s1;
	logic                          sw_sub_s1;
	logic [osp_pkg::MACH_W-1:0]    sw_i_s1;
	logic                          sw_issue;

	logic                          j_last, i_last;
	logic                          j_step, j_clr, i_step, i_clr;
	logic                          start;
	logic [osp_pkg::LOAD_W-1:0]    top_c;
	logic [osp_pkg::MACH_W-1:0]    mu_c;
	logic                          better;

	osp_pkg::div_req_t div_req;
	osp_pkg::div_rsp_t div_rsp;

	osp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign start  = ld_fire && ld.last_entry;
	assign j_last = j_q == nj_m1;
	assign i_last = i_q == nm_m1;
	assign better = !found_q || (div_rsp.quotient < best_q);
	assign idle   = state_q == osp_pkg::S_IDLE;

	always_comb begin
		top_c = '0;
		mu_c  = '0;
		for (int m = 0; m < osp_pkg::MAX_MACHINES; m++) begin
			if (osp_pkg::MACH_W'(m) <= nm_m1 && loads_q[m] > top_c) begin
				top_c = loads_q[m];
				mu_c  = osp_pkg::MACH_W'(m);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= osp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		tm_raddr         = {j_q, mu_q};
		adj_we           = 1'b0;
		adj_wdata        = adj_s1 - prod_s1;
		div_req.start    = 1'b0;
		div_req.dividend = adj_rd;
		div_req.divisor  = t_rd;
		res_push         = 1'b0;
		sw_issue         = 1'b0;
		j_step           = 1'b0;
		j_clr            = 1'b0;
		i_step           = 1'b0;
		i_clr            = 1'b0;
		unique case (state_q)
			osp_pkg::S_IDLE: begin
				if (start) begin
					state_d = osp_pkg::S_INIT;
					i_clr   = 1'b1;
					j_clr   = 1'b1;
				end
			end
			osp_pkg::S_INIT: begin
				tm_raddr  = {j_q, i_q};
				sw_issue  = 1'b1;
				adj_we    = i_q == '0;
				adj_wdata = osp_pkg::ADJ_W'({w_q[j_q], {osp_pkg::FRAC_BITS{1'b0}}});
				i_step    = 1'b1;
				if (i_last) begin
					i_clr  = 1'b1;
					j_step = 1'b1;
					if (j_last) begin
						j_clr   = 1'b1;
						state_d = osp_pkg::S_MAX;
					end
				end
			end
			osp_pkg::S_MAX: begin
				j_clr = 1'b1;
				if (!sw_v_s1) begin
					state_d = osp_pkg::S_SCAN_RD;
				end
			end
			osp_pkg::S_SCAN_RD: begin
				if (flag_q[j_q]) begin
					j_step  = 1'b1;
					state_d = j_last ? osp_pkg::S_SCAN_END : osp_pkg::S_SCAN_RD;
				end else begin
					state_d = osp_pkg::S_SCAN_CHK;
				end
			end
			osp_pkg::S_SCAN_CHK: begin
				if (t_rd == '0) begin
					j_step  = 1'b1;
					state_d = j_last ? osp_pkg::S_SCAN_END : osp_pkg::S_SCAN_RD;
				end else begin
					div_req.start = 1'b1;
					state_d       = osp_pkg::S_SCAN_DIV;
				end
			end
			osp_pkg::S_SCAN_DIV: begin
				if (div_rsp.done) begin
					j_step  = 1'b1;
					state_d = j_last ? osp_pkg::S_SCAN_END : osp_pkg::S_SCAN_RD;
				end
			end
			osp_pkg::S_SCAN_END: begin
				j_clr   = 1'b1;
				state_d = found_q ? osp_pkg::S_UPD_RD : osp_pkg::S_PICK;
			end
			osp_pkg::S_UPD_RD: begin
				if (flag_q[j_q]) begin
					j_step  = 1'b1;
					state_d = j_last ? osp_pkg::S_PICK : osp_pkg::S_UPD_RD;
				end else begin
					state_d = osp_pkg::S_UPD_MUL;
				end
			end
			osp_pkg::S_UPD_MUL: begin
				state_d = osp_pkg::S_UPD_WR;
			end
			osp_pkg::S_UPD_WR: begin
				adj_we  = 1'b1;
				j_step  = 1'b1;
				state_d = j_last ? osp_pkg::S_PICK : osp_pkg::S_UPD_RD;
			end
			osp_pkg::S_PICK: begin
				i_clr   = 1'b1;
				state_d = osp_pkg::S_SUB;
			end
			osp_pkg::S_SUB: begin
				tm_raddr = {pick_q, i_q};
				sw_issue = 1'b1;
				i_step   = 1'b1;
				if (i_last) begin
					i_clr   = 1'b1;
					state_d = osp_pkg::S_EMIT;
				end
			end
			osp_pkg::S_EMIT: begin
				if (res_free) begin
					res_push = 1'b1;
					state_d  = (k_q == '0) ? osp_pkg::S_IDLE : osp_pkg::S_MAX;
				end
			end
			default: begin
				state_d = osp_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q       <= '0;
			i_q       <= '0;
			k_q       <= '0;
			flag_q    <= '0;
			found_q   <= 1'b0;
			first_v_q <= 1'b0;
			sw_v_s1   <= 1'b0;
		end else begin
			sw_v_s1 <= sw_issue;
			if (j_clr) begin
				j_q <= '0;
			end else if (j_step) begin
				j_q <= j_q + 1'b1;
			end
			if (i_clr) begin
				i_q <= '0;
			end else if (i_step) begin
				i_q <= i_q + 1'b1;
			end
			if (state_q == osp_pkg::S_IDLE && start) begin
				k_q    <= nj_m1;
				flag_q <= '0;
			end
			if (res_push) begin
				k_q            <= k_q - 1'b1;
				flag_q[pick_q] <= 1'b1;
			end
			if (state_q == osp_pkg::S_MAX) begin
				found_q   <= 1'b0;
				first_v_q <= 1'b0;
			end
			if (state_q == osp_pkg::S_SCAN_RD && !flag_q[j_q]) begin
				first_v_q <= 1'b1;
			end
			if (state_q == osp_pkg::S_SCAN_DIV && div_rsp.done && better) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_fire) begin
			time_mem[{ld.job_index, ld.machine_index}] <= ld.processing_time;
			w_q[ld.job_index]                          <= ld.job_weight;
		end
		t_rd <= time_mem[tm_raddr];
	end

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[j_q] <= adj_wdata;
		end
		adj_rd <= adj_mem[j_q];
	end

	always_ff @(posedge clk) begin
		sw_sub_s1 <= state_q == osp_pkg::S_SUB;
		sw_i_s1   <= i_q;
		if (state_q == osp_pkg::S_IDLE && start) begin
			for (int m = 0; m < osp_pkg::MAX_MACHINES; m++) begin
				loads_q[m] <= '0;
			end
			total_q <= '0;
		end else if (sw_v_s1) begin
			loads_q[sw_i_s1] <= sw_sub_s1 ? loads_q[sw_i_s1] - osp_pkg::LOAD_W'(t_rd)
			                              : loads_q[sw_i_s1] + osp_pkg::LOAD_W'(t_rd);
		end
		if (state_q == osp_pkg::S_MAX) begin
			top_q <= top_c;
			mu_q  <= mu_c;
		end
		if (state_q == osp_pkg::S_SCAN_RD && !flag_q[j_q] && !first_v_q) begin
			first_q <= j_q;
		end
		if (state_q == osp_pkg::S_SCAN_DIV && div_rsp.done && better) begin
			best_q <= div_rsp.quotient;
			pick_q <= j_q;
		end
		if (state_q == osp_pkg::S_SCAN_END && !found_q) begin
			pick_q <= first_q;
		end
		if (state_q == osp_pkg::S_UPD_MUL) begin
			prod_s1 <= osp_pkg::ADJ_W'(best_q * t_rd);
			adj_s1  <= adj_rd;
		end
		if (state_q == osp_pkg::S_PICK) begin
			wprod_q <= top_q * w_q[pick_q];
		end
		if (state_q == osp_pkg::S_SUB && i_q == '0) begin
			total_q <= total_q + osp_pkg::SUM_W'(wprod_q);
		end
	end

	assign res.schedule_position = k_q;
	assign res.scheduled_job     = pick_q;
	assign res.completion_time   = top_q;
	assign res.weighted_sum      = total_q;
	assign res.last_result       = k_q == '0;

endmodule

// File: design/open_shop_primal_dual_scheduler_top.sv
// Top level: open shop primal-dual scheduler with configuration registers and result register.
// Load entries are taken one per cycle while the scheduler is idle. The entry marked last
// starts a scheduling pass during which load ready stays low: an init sweep over jobs x
// machines, then for each position a scan of the unplaced jobs through the bit-serial ratio
// divider, a weight write-back through the adjusted weight memory and a sweep over the
// machines. Results leave through a register, so the pass keeps working while one result
// waits to be taken.
module open_shop_primal_dual_scheduler_top (
	input  logic                              clk,
	input  logic                              arst_n,
	osp_load_if.sink                          load,
	osp_result_if.source                      result,
	input  logic                              cfg_we,
	input  logic [osp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [osp_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [osp_pkg::CFG_JOBS_W-1:0] jobs_q;
	logic [osp_pkg::CFG_MACH_W-1:0] mach_q;
	logic [osp_pkg::JOB_W-1:0]      nj_m1;
	logic [osp_pkg::MACH_W-1:0]     nm_m1;
	logic                           idle;
	logic                           res_push;
	logic                           res_free;
	logic                           out_valid_q;
	osp_pkg::result_t               res;
	osp_pkg::result_t               res_q;
	osp_pkg::load_t                 ld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jobs_q <= osp_pkg::CFG_JOBS_W'(osp_pkg::MAX_JOBS);
			mach_q <= osp_pkg::CFG_MACH_W'(osp_pkg::MAX_MACHINES);
		end else if (cfg_we) begin
			unique case (osp_pkg::cfg_reg_t'(cfg_index))
				osp_pkg::CFG_JOBS:     jobs_q <= cfg_data;
				osp_pkg::CFG_MACHINES: mach_q <= cfg_data[osp_pkg::CFG_MACH_W-1:0];
				default: ;
			endcase
		end
	end

	assign nj_m1 = (jobs_q == '0) ? '0 :
	               (jobs_q > osp_pkg::CFG_JOBS_W'(osp_pkg::MAX_JOBS)) ?
	               osp_pkg::JOB_W'(osp_pkg::MAX_JOBS - 1) : osp_pkg::JOB_W'(jobs_q - 1'b1);
	assign nm_m1 = (mach_q == '0) ? '0 :
	               (mach_q > osp_pkg::CFG_MACH_W'(osp_pkg::MAX_MACHINES)) ?
	               osp_pkg::MACH_W'(osp_pkg::MAX_MACHINES - 1) : osp_pkg::MACH_W'(mach_q - 1'b1);

	assign ld.job_index       = load.job_index;
	assign ld.machine_index   = load.machine_index;
	assign ld.processing_time = load.processing_time;
	assign ld.job_weight      = load.job_weight;
	assign ld.last_entry      = load.last_entry;
	assign load.ready         = idle;

	assign res_free = !out_valid_q || result.ready;

	osp_sched u_sched (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ld),
		.ld_fire  (load.valid && load.ready),
		.nj_m1    (nj_m1),
		.nm_m1    (nm_m1),
		.res_free (res_free),
		.idle     (idle),
		.res_push (res_push),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res_push || (out_valid_q && !result.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q <= res;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.schedule_position = res_q.schedule_position;
	assign result.scheduled_job     = res_q.scheduled_job;
	assign result.completion_time   = res_q.completion_time;
	assign result.weighted_sum      = res_q.weighted_sum;
	assign result.last_result       = res_q.last_result;

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (!out_valid_q || result.ready))
		else $error("result pushed into a full output register");

	a_push_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !idle)
		else $error("result pushed while scheduler idle");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(idle) |-> $past(res_push) && res_q.last_result)
		else $error("scheduler went idle without emitting position zero");

endmodule
